// ===== hdl/edge_nms_pkg.sv =====
// shared constants for the edge non-maximum suppression block
`timescale 1ns / 1ps
package edge_nms_pkg;

  localparam int CFG_W   = 11;
  localparam int MAG_W   = 8;
  localparam int DIR_W   = 8;
  localparam int MIN_DIM = 3;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [DIR_W-1:0] dir_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  localparam dir_t DIR_HORIZ   = 8'd0;
  localparam dir_t DIR_DIAG_UP = 8'd45;
  localparam dir_t DIR_VERT    = 8'd90;

endpackage

// ===== hdl/edge_non_max_suppression.sv =====
// Streaming 3x3 non-maximum suppression over a raster stream of gradient pixels. One word is
// accepted every clock while in_tready is high. A pixel word reads three line stores at its
// column into registers, and the 3x3 window compare runs in one pass from those registers into
// the result register. The result is valid on out_tvalid from the result register, which the
// word causing it reaches through the input register. The result for a pixel belongs to the
// word W+1 positions later. After the last pixel of a frame, W+1 flush words drain the remaining
// border results, and the final one has tlast set. Pixel words past the frame end and flush
// words before it are taken and give no result. When the result register holds a word that is
// not taken, one more word waits in the input register and in_tready drops. Frame sizes are
// clamped to 3..MAX and may change between any two words. in_tready is low while cfg_wen is
// high. After a width write it stays low while the column of the next pixel is found again
// from the pixel count.
`timescale 1ns / 1ps
module edge_non_max_suppression #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wen,
  input  logic                          cfg_index,
  input  logic [edge_nms_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // magnitude, direction
  input  logic [0:0]                    in_tuser,   // cmd
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // edge_value
  output logic                          out_tlast   // frame_last
);
  import edge_nms_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int TW = WW + HW;
  localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DW = PW + WW - 1;
  localparam int RW = $clog2(PW + 1);
  localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  // frame size
  logic [WW-1:0] w_eff_r;
  logic [HW-1:0] h_eff_r;
  logic [WW-1:0] w_new;
  logic [TW-1:0] total;

  // position counters
  logic [XW-1:0] x_r;
  logic [PW-1:0] pix_cnt_r;
  logic [PW-1:0] res_cnt_r;

  // column search after a width write
  logic [RW-1:0] rcnt_r;
  logic [PW-1:0] rem_r;
  logic [DW-1:0] div_r;
  logic [PW-1:0] rem_step;
  logic          recalc;
  logic          width_wr;

  // line stores
  mag_t mag_above_mem  [MAX_WIDTH];
  mag_t mag_centre_mem [MAX_WIDTH];
  dir_t dir_centre_mem [MAX_WIDTH];
  mag_t above_q;
  mag_t centre_q;
  dir_t dir_q;

  // input stage
  logic          s1_valid_r;
  logic          s1_shift_r;
  logic          s1_emit_r;
  logic          s1_border_r;
  logic          s1_last_r;
  logic [XW-1:0] s1_x_r;
  mag_t          s1_mag_r;

  // window columns: win1_r two columns back, win2_r one column back, rows top to bottom
  mag_t win1_r [3];
  mag_t win2_r [3];
  dir_t cdir_r;

  logic out_valid_r;
  mag_t out_data_r;
  logic out_last_r;

  logic    in_fire;
  logic    s1_fire;
  logic    is_flush;
  logic    full;
  logic    pix_ok;
  logic    early;
  logic    emit;
  logic    border;
  logic    x_last;
  logic    res_last;
  mag_t    in_mag;
  dir_t    in_dir;
  mag_t    c0 [3];
  mag_t    c1 [3];
  mag_t    c2 [3];
  mag_t    n1;
  mag_t    n2;
  mag_t    kept;

  assign in_mag   = in_tdata[7:0];
  assign in_dir   = in_tdata[15:8];
  assign is_flush = (cmd_t'(in_tuser[0]) == CMD_FLUSH);
  assign total    = TW'(w_eff_r) * TW'(h_eff_r);
  assign full     = (32'(pix_cnt_r) >= 32'(total));
  assign pix_ok   = !is_flush && !full;
  assign early    = (32'(pix_cnt_r) < 32'(w_eff_r) + 32'd1);
  assign emit     = is_flush ? full : (pix_ok && !early);
  assign border   = is_flush || (32'(pix_cnt_r) < (32'(w_eff_r) << 1)) || (x_r <= XW'(1));
  assign x_last   = (WW'(x_r) == w_eff_r - WW'(1));
  assign res_last = (32'(res_cnt_r) + 32'd1 >= 32'(total));

  assign width_wr = cfg_wen && (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH);
  assign recalc   = (rcnt_r != RW'(0));
  assign rem_step = (DW'(rem_r) >= div_r) ? PW'(DW'(rem_r) - div_r) : rem_r;

  assign s1_fire   = s1_valid_r && (!s1_emit_r || !out_valid_r || out_tready);
  assign in_tready = (!s1_valid_r || s1_fire) && !recalc && !cfg_wen;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    if (cfg_wdata < CFG_W'(MIN_DIM)) w_new = WW'(MIN_DIM);
    else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) w_new = WW'(MAX_WIDTH);
    else w_new = WW'(cfg_wdata);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WW'(W_RST);
      h_eff_r <= HW'(H_RST);
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          w_eff_r <= w_new;
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_wdata < CFG_W'(MIN_DIM)) h_eff_r <= HW'(MIN_DIM);
          else if (32'(cfg_wdata) > 32'(MAX_HEIGHT)) h_eff_r <= HW'(MAX_HEIGHT);
          else h_eff_r <= HW'(cfg_wdata);
        end
        default: ;
      endcase
    end
  end

  // column = pixel count mod width, one quotient bit per clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcnt_r <= '0;
    end else if (width_wr) begin
      rcnt_r <= RW'(PW);
    end else if (recalc) begin
      rcnt_r <= rcnt_r - RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (width_wr) begin
      rem_r <= pix_cnt_r;
      div_r <= DW'(w_new) << (PW - 1);
    end else if (recalc) begin
      rem_r <= rem_step;
      div_r <= div_r >> 1;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r       <= '0;
      pix_cnt_r <= '0;
      res_cnt_r <= '0;
    end else if (recalc) begin
      if (rcnt_r == RW'(1)) x_r <= XW'(rem_step);
    end else if (in_fire) begin
      if (emit && res_last) begin
        x_r       <= '0;
        pix_cnt_r <= '0;
        res_cnt_r <= '0;
      end else begin
        if (emit) res_cnt_r <= res_cnt_r + PW'(1);
        if (pix_ok) begin
          pix_cnt_r <= pix_cnt_r + PW'(1);
          if (x_last) begin
            x_r <= '0;
          end else begin
            x_r <= x_r + XW'(1);
          end
        end
      end
    end
  end

  // line stores, read before write at the same column
  always_ff @(posedge clk) begin
    if (in_fire && pix_ok) begin
      above_q           <= mag_above_mem[x_r];
      centre_q          <= mag_centre_mem[x_r];
      dir_q             <= dir_centre_mem[x_r];
      mag_centre_mem[x_r] <= in_mag;
      dir_centre_mem[x_r] <= in_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_shift_r) begin
      mag_above_mem[s1_x_r] <= centre_q;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_shift_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
      s1_shift_r <= pix_ok;
      s1_emit_r  <= emit;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_border_r <= border;
      s1_last_r   <= res_last;
      s1_x_r      <= x_r;
      s1_mag_r    <= in_mag;
    end
  end

  // window after the shift
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      c0[r] = win1_r[r];
      c1[r] = win2_r[r];
    end
    c2[0] = above_q;
    c2[1] = centre_q;
    c2[2] = s1_mag_r;
  end

  always_comb begin
    if (cdir_r == DIR_HORIZ) begin
      n1 = c0[1];
      n2 = c2[1];
    end else if (cdir_r == DIR_VERT) begin
      n1 = c1[0];
      n2 = c1[2];
    end else if (cdir_r == DIR_DIAG_UP) begin
      n1 = c0[2];
      n2 = c2[0];
    end else begin
      n1 = c0[0];
      n2 = c2[2];
    end
    kept = ((c1[1] >= n1) && (c1[1] >= n2)) ? c1[1] : '0;
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_shift_r) begin
      for (int r = 0; r < 3; r++) begin
        win1_r[r] <= c1[r];
        win2_r[r] <= c2[r];
      end
      cdir_r <= dir_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit_r) begin
      out_data_r <= s1_border_r ? '0 : kept;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (cfg_wen || recalc ||
                    (s1_valid_r && s1_emit_r && out_valid_r && !out_tready)))
    else $error("input stalled without a blocked result");

  a_early_flush_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_flush && !full) |=> (s1_valid_r && !s1_emit_r))
    else $error("flush before frame end produced a result");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_valid_r && s1_emit_r))
    else $error("result without an emitting word");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_emit_r && s1_border_r) |=> (out_tvalid && out_tdata == '0))
    else $error("border result not zero");
`endif

endmodule
